// ----- src/bis_pkg.sv -----
`timescale 1ns / 1ps

package bis_pkg;

   // Sequencer phases, as reported on the result word.
   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_PREHEAT = 4'd1,
      PH_FAN     = 4'd2,
      PH_AIR     = 4'd3,
      PH_SPARK   = 4'd4,
      PH_DETECT  = 4'd5,
      PH_BURN    = 4'd6,
      PH_NOOIL   = 4'd7,
      PH_FAULT   = 4'd8
   } phase_type;

   // LED pattern codes.
   localparam logic [1:0] LED_OFF  = 2'd0;
   localparam logic [1:0] LED_SLOW = 2'd1;
   localparam logic [1:0] LED_FAST = 2'd2;

   // Oil heater command codes.
   localparam logic [1:0] HEAT_NONE = 2'd0;
   localparam logic [1:0] HEAT_OFF  = 2'd1;
   localparam logic [1:0] HEAT_ON   = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAN_TICKS        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AIR_TICKS        = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARK_TICKS      = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETECT_TICKS     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAME_HOLD_TICKS = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_LIMIT      = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEATER_CTRL      = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOOIL_TICKS      = 4'd7;

   // Counter widths and saturation points.
   localparam int unsigned TICK_W    = 17;
   localparam int unsigned ATTEMPT_W = 9;
   localparam int unsigned HOLD_W    = 16;
   localparam logic [TICK_W-1:0]    TICK_MAX    = '1;
   localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;

   // One input word: a tick with its sensor flags.
   typedef struct packed {
      logic restart;
      logic oil_empty;
      logic heat_demand;
      logic oil_cold;
      logic flame_seen;
   } req_word_type;

   // One result word: relay drives, heater command, LEDs and status.
   typedef struct packed {
      logic       fan_on;
      logic       air_on;
      logic       spark_on;
      logic [1:0] oil_heater_cmd;
      logic [1:0] led_a_mode;
      logic [1:0] led_b_mode;
      logic [3:0] phase;
      logic       no_flame_fault;
   } rsp_word_type;

   // Configuration registers as seen by the sequencer core.
   typedef struct packed {
      logic [15:0] fan_ticks;
      logic [15:0] air_ticks;
      logic [15:0] spark_ticks;
      logic [15:0] detect_ticks;
      logic [15:0] flame_hold_ticks;
      logic [7:0]  retry_limit;
      logic        heater_ctrl;
      logic [15:0] nooil_ticks;
   } cfg_type;

endpackage

// ----- src/bis_step.sv -----
`timescale 1ns / 1ps

module bis_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  bis_pkg::cfg_type      cfg,
   input  bis_pkg::req_word_type req_word,
   output bis_pkg::rsp_word_type rsp_word
);
   import bis_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [ATTEMPT_W-1:0]   attempts_ff, attempts_in;
   logic [HOLD_W-1:0]      hold_ff, hold_in;
   logic [1:0]             led_a_ff, led_a_in;
   logic [1:0]             led_b_ff, led_b_in;
   logic                   no_flame_ff, no_flame_in;

   // Sequencer state advances once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= '0;
         attempts_ff <= '0;
         hold_ff     <= '0;
         led_a_ff    <= LED_OFF;
         led_b_ff    <= LED_OFF;
         no_flame_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         attempts_ff <= attempts_in;
         hold_ff     <= hold_in;
         led_a_ff    <= led_a_in;
         led_b_ff    <= led_b_in;
         no_flame_ff <= no_flame_in;
      end
   end

   // Next state and result for the word on the input.
   always_comb begin
      phase_type           ph;
      logic [TICK_W-1:0]   tc_sat;
      logic [15:0]         limit;
      logic                over;
      logic [1:0]          heat;
      logic [1:0]          off_cmd;
      logic [HOLD_W-1:0]   hold_nx;

      ph          = phase_ff;
      tick_in     = tick_ff;
      attempts_in = attempts_ff;
      hold_in     = hold_ff;
      led_a_in    = led_a_ff;
      led_b_in    = led_b_ff;
      no_flame_in = no_flame_ff;
      heat        = HEAT_NONE;
      off_cmd     = cfg.heater_ctrl ? HEAT_OFF : HEAT_NONE;
      tc_sat      = tick_ff;
      limit       = cfg.fan_ticks;
      over        = 1'b0;
      hold_nx     = hold_ff;

      if (req_word.restart) begin
         ph          = PH_IDLE;
         attempts_in = '0;
      end else begin
         // Overrides: no oil first, then loss of demand, then start on demand.
         if (req_word.oil_empty) begin
            if (ph != PH_NOOIL && ph != PH_FAULT) begin
               tick_in = '0;
               ph      = PH_NOOIL;
            end
         end else if (!req_word.heat_demand) begin
            if (ph != PH_FAULT) begin
               ph = PH_IDLE;
            end
         end else if (ph == PH_IDLE) begin
            ph = PH_PREHEAT;
         end

         // Timed phases share one saturating counter and one compare.
         tc_sat = (tick_in != TICK_MAX) ? tick_in + 1'b1 : tick_in;
         case (ph)
            PH_AIR:    limit = cfg.air_ticks;
            PH_SPARK:  limit = cfg.spark_ticks;
            PH_DETECT: limit = cfg.detect_ticks;
            PH_NOOIL:  limit = cfg.nooil_ticks;
            default:   limit = cfg.fan_ticks;
         endcase
         over = tc_sat > {1'b0, limit};

         case (ph)
            PH_FAULT: begin
               led_a_in = LED_SLOW;
               led_b_in = LED_SLOW;
               heat     = off_cmd;
            end
            PH_IDLE: begin
               led_a_in = LED_OFF;
               led_b_in = LED_SLOW;
               tick_in  = '0;
               heat     = off_cmd;
            end
            PH_PREHEAT: begin
               if (cfg.heater_ctrl) begin
                  heat = HEAT_ON;
               end
               if (!req_word.oil_cold) begin
                  ph      = PH_FAN;
                  tick_in = '0;
                  if (attempts_ff != ATTEMPT_MAX) begin
                     attempts_in = attempts_ff + 1'b1;
                  end
               end
            end
            PH_FAN: begin
               tick_in = tc_sat;
               if (over) begin
                  ph      = PH_AIR;
                  tick_in = '0;
               end
            end
            PH_AIR: begin
               tick_in = tc_sat;
               if (over) begin
                  ph       = PH_SPARK;
                  led_a_in = LED_FAST;
                  tick_in  = '0;
               end
            end
            PH_SPARK: begin
               tick_in = tc_sat;
               if (over) begin
                  ph       = PH_DETECT;
                  led_a_in = LED_OFF;
                  led_b_in = LED_FAST;
                  tick_in  = '0;
               end
            end
            PH_DETECT: begin
               tick_in = tc_sat;
               if (over) begin
                  // Out of attempts ends in a sticky fault, otherwise retry.
                  if (attempts_ff > {1'b0, cfg.retry_limit}) begin
                     ph          = PH_FAULT;
                     no_flame_in = 1'b1;
                  end else begin
                     ph = PH_IDLE;
                  end
                  tick_in = '0;
               end else if (req_word.flame_seen) begin
                  led_a_in    = LED_OFF;
                  led_b_in    = LED_SLOW;
                  ph          = PH_BURN;
                  tick_in     = '0;
                  attempts_in = '0;
               end
            end
            PH_BURN: begin
               // Flame may drop out for the hold time before burn ends.
               if (req_word.flame_seen) begin
                  hold_nx = cfg.flame_hold_ticks;
               end else if (hold_ff != '0) begin
                  hold_nx = hold_ff - 1'b1;
               end
               hold_in = hold_nx;
               if (hold_nx == '0) begin
                  ph = PH_IDLE;
               end
            end
            PH_NOOIL: begin
               heat    = off_cmd;
               tick_in = tc_sat;
               if (over) begin
                  ph      = PH_FAULT;
                  tick_in = '0;
               end else if (!req_word.oil_empty) begin
                  ph = PH_IDLE;
               end
            end
            default: begin
               ph = PH_IDLE;
            end
         endcase
      end

      phase_in = ph;

      rsp_word.fan_on         = (ph >= PH_FAN) && (ph <= PH_BURN);
      rsp_word.air_on         = (ph >= PH_AIR) && (ph <= PH_BURN);
      rsp_word.spark_on       = (ph == PH_SPARK);
      rsp_word.oil_heater_cmd = heat;
      rsp_word.led_a_mode     = led_a_in;
      rsp_word.led_b_mode     = led_b_in;
      rsp_word.phase          = ph;
      rsp_word.no_flame_fault = no_flame_in;
   end

endmodule

// ----- src/burner_ignition_sequencer.sv -----
`timescale 1ns / 1ps

// Oil burner ignition sequencer. Each input word is one timing tick (10 ms
// nominal) with the oil, demand, oil temperature and flame flags, or a
// restart request; each word yields exactly one result word with the relay
// drives, heater command, LED patterns, phase and no-flame fault flag. The
// result goes to the output register, or to the one-word skid stage while the
// output register is stalled; a word can be accepted every cycle while the
// skid stage is empty. The whole state update is one pass of logic from the
// state registers to the output register, and the skid stage takes one more
// word while a result is stalled. Configuration writes are always ready and
// apply from the next accepted word on; writes to unknown indexes are dropped.
module burner_ignition_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bis_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bis_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bis_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [15:0]                          csr_wdata
);
   import bis_pkg::*;

   cfg_type       cfg_ff;
   rsp_word_type  step_word;
   rsp_word_type  out_ff;
   rsp_word_type  skid_ff;
   logic          out_valid_ff;
   logic          skid_valid_ff;
   logic          accept;
   logic          drain;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fan_ticks        <= 16'd1000;
         cfg_ff.air_ticks        <= 16'd15;
         cfg_ff.spark_ticks      <= 16'd100;
         cfg_ff.detect_ticks     <= 16'd500;
         cfg_ff.flame_hold_ticks <= 16'd300;
         cfg_ff.retry_limit      <= 8'd3;
         cfg_ff.heater_ctrl      <= 1'b1;
         cfg_ff.nooil_ticks      <= 16'd30000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FAN_TICKS:        cfg_ff.fan_ticks        <= csr_wdata;
            CSR_AIR_TICKS:        cfg_ff.air_ticks        <= csr_wdata;
            CSR_SPARK_TICKS:      cfg_ff.spark_ticks      <= csr_wdata;
            CSR_DETECT_TICKS:     cfg_ff.detect_ticks     <= csr_wdata;
            CSR_FLAME_HOLD_TICKS: cfg_ff.flame_hold_ticks <= csr_wdata;
            CSR_RETRY_LIMIT:      cfg_ff.retry_limit      <= csr_wdata[7:0];
            CSR_HEATER_CTRL:      cfg_ff.heater_ctrl      <= csr_wdata[0];
            CSR_NOOIL_TICKS:      cfg_ff.nooil_ticks      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input is held off only while the skid stage is occupied.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign drain     = out_valid_ff && !rsp_stall;

   bis_step u_step (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cfg      (cfg_ff),
      .req_word (req_word),
      .rsp_word (step_word)
   );

   // Output register with a one-word skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (drain) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || drain) begin
         out_valid_ff <= accept;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (drain) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || drain) begin
         if (accept) begin
            out_ff <= step_word;
         end
      end else if (accept) begin
         skid_ff <= step_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

// ----- src/bis_checker.sv -----
`timescale 1ns / 1ps

module bis_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input bis_pkg::rsp_word_type            rsp_word
);
   import bis_pkg::*;

   // A stalled result word stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word dropped or changed while stalled");

   // An accepted input word is always followed by a valid result in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no result");

   // Input is only held off when a result is waiting downstream.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // Relays follow the reported phase.
   a_relays: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.spark_on == (rsp_word.phase == PH_SPARK))
                 && (!rsp_word.air_on || rsp_word.fan_on)
                 && (!rsp_word.fan_on || rsp_word.phase != PH_IDLE))
      else $error("relay drives inconsistent with phase");

   // The heater command never takes the unused code.
   a_heat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.oil_heater_cmd != 2'd3))
      else $error("invalid oil heater command");

endmodule

bind burner_ignition_sequencer bis_checker u_bis_checker (.*);
